// ----- rtl/core/value_noise_fbm_3d_assert.svh -----
// Assertion macros for the value noise fractal block.
`ifndef VALUE_NOISE_FBM_3D_ASSERT_SVH
`define VALUE_NOISE_FBM_3D_ASSERT_SVH
// Implication checked every clock outside reset.
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/vnf_pkg.sv -----
// Shared constants and arithmetic helpers for the value noise block.
package vnf_pkg;
    localparam logic [31:0] HASH_M1 = 32'h7feb352d;
    localparam logic [31:0] HASH_M2 = 32'h846ca68b;
    localparam logic [31:0] PRIME_X = 32'd374761393;
    localparam logic [31:0] PRIME_Y = 32'd668265263;
    localparam logic [31:0] PRIME_Z = 32'd2147483647;
    localparam logic [23:0] FRAC_MAX = 24'hffffff;
    localparam logic [24:0] FRAC_ONE = 25'h1000000;
    localparam logic [31:0] STEP_PLAIN = 32'd1013;
    localparam logic [31:0] STEP_RIDGE = 32'd1777;
    localparam logic [17:0] LAC_PLAIN = 18'd133038;
    localparam logic [17:0] LAC_RIDGE = 18'd136315;
    localparam logic OP_PLAIN = 1'b0;
    localparam logic OP_RIDGE = 1'b1;

    function automatic logic [31:0] xs16(input logic [31:0] v);
        xs16 = v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] xs15(input logic [31:0] v);
        xs15 = v ^ (v >> 15);
    endfunction
endpackage

// ----- rtl/core/value_noise_fbm_3d.sv -----
// Top level of the fractal value noise pipeline.
// value_noise_fbm_3d: fully pipelined, one request accepted every clock (busy is held low).
// Each request runs through OCTAVES octave sections of 26 register stages each, plus one
// output stage before the result strobe. Results appear in request order and cannot be
// held off by the receiver.
module value_noise_fbm_3d
#(
    parameter int OCTAVES = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] seed,
    output logic        done,
    output logic [23:0] noise_value
);
    import vnf_pkg::*;
    `include "value_noise_fbm_3d_assert.svh"

    // Chain of octave sections; element 0 is the request itself.
    logic        cv [OCTAVES+1];
    logic        co [OCTAVES+1];
    logic [31:0] cx [OCTAVES+1];
    logic [31:0] cy [OCTAVES+1];
    logic [31:0] cz [OCTAVES+1];
    logic [31:0] cs [OCTAVES+1];
    logic [24:0] ct [OCTAVES+1];

    assign busy  = 1'b0;
    assign cv[0] = start & ~busy;
    assign co[0] = opcode;
    assign cx[0] = pos_x;
    assign cy[0] = pos_y;
    assign cz[0] = pos_z;
    assign cs[0] = seed;
    assign ct[0] = '0;

    for (genvar i = 0; i < OCTAVES; i++)
    begin : g_oct
        vnf_octave #(.IDX(i)) u_oct
        (
            .clk(clk), .rst_n(rst_n),
            .in_vld(cv[i]), .in_op(co[i]),
            .in_px(cx[i]), .in_py(cy[i]), .in_pz(cz[i]),
            .in_seed(cs[i]), .in_total(ct[i]),
            .out_vld(cv[i+1]), .out_op(co[i+1]),
            .out_px(cx[i+1]), .out_py(cy[i+1]), .out_pz(cz[i+1]),
            .out_seed(cs[i+1]), .out_total(ct[i+1])
        );
    end

    // Final clamp to 24 bits; the octave weights keep even the ridged sum below 2^24.
    logic        done_reg;
    logic [23:0] nv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cv[OCTAVES];
    end
    always_ff @(posedge clk)
        nv_reg <= (ct[OCTAVES] > 25'(FRAC_MAX)) ? FRAC_MAX : ct[OCTAVES][23:0];

    assign done        = done_reg;
    assign noise_value = nv_reg;

    `VN_ASSERT_NEXT(a_done_follows, clk, rst_n, cv[OCTAVES], done)
    `VN_ASSERT_IMP(a_never_busy, clk, rst_n, start, !busy)
    `VN_ASSERT_NEXT(a_plain_no_clamp, clk, rst_n,
        cv[OCTAVES] && co[OCTAVES] == OP_PLAIN, nv_reg == $past(ct[OCTAVES][23:0]))
endmodule

// ----- rtl/core/vnf_mix.sv -----
// Pipelined 32-bit multiply-xorshift hash, four register stages.
module vnf_mix
(
    input  logic        clk,
    input  logic [31:0] din,
    output logic [31:0] dout
);
    import vnf_pkg::*;

    logic [31:0] s1_reg, s2_reg, s3_reg, s4_reg;

    always_ff @(posedge clk)
    begin
        s1_reg <= xs16(din);
        s2_reg <= s1_reg * HASH_M1;
        s3_reg <= xs15(s2_reg);
        s4_reg <= s3_reg * HASH_M2;
    end

    assign dout = xs16(s4_reg);
endmodule

// ----- rtl/core/vnf_octave.sv -----
// One octave: corner hashes, fade, trilinear blend, ridge, weighted total; also the next octave's point.
module vnf_octave
#(
    parameter int IDX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic        in_op,
    input  logic [31:0] in_px,
    input  logic [31:0] in_py,
    input  logic [31:0] in_pz,
    input  logic [31:0] in_seed,
    input  logic [24:0] in_total,
    output logic        out_vld,
    output logic        out_op,
    output logic [31:0] out_px,
    output logic [31:0] out_py,
    output logic [31:0] out_pz,
    output logic [31:0] out_seed,
    output logic [24:0] out_total
);
    import vnf_pkg::*;

    // Stage count of this octave; side data is delayed by the same amount.
    localparam int LAT = 26;

    // ---- stage A: cell, fraction, lattice products, octave seed
    logic [31:0] cx0_reg, cy0_reg, cz0_reg, sd_reg;
    logic [23:0] tx_reg, ty_reg, tz_reg;
    logic [31:0] oseed;
    assign oseed = in_seed + 32'(IDX) * (in_op ? STEP_RIDGE : STEP_PLAIN);

    always_ff @(posedge clk)
    begin
        cx0_reg <= {{16{in_px[31]}}, in_px[31:16]};
        cy0_reg <= {{16{in_py[31]}}, in_py[31:16]};
        cz0_reg <= {{16{in_pz[31]}}, in_pz[31:16]};
        tx_reg  <= {in_px[15:0], 8'd0};
        ty_reg  <= {in_py[15:0], 8'd0};
        tz_reg  <= {in_pz[15:0], 8'd0};
        sd_reg  <= oseed;
    end

    // ---- stage B: axis products
    logic [31:0] mx0_reg, mx1_reg, my0_reg, my1_reg, mz0_reg, mz1_reg;
    always_ff @(posedge clk)
    begin
        mx0_reg <= cx0_reg * PRIME_X;
        mx1_reg <= (cx0_reg + 32'd1) * PRIME_X;
        my0_reg <= cy0_reg * PRIME_Y;
        my1_reg <= (cy0_reg + 32'd1) * PRIME_Y;
        mz0_reg <= cz0_reg * PRIME_Z;
        mz1_reg <= (cz0_reg + 32'd1) * PRIME_Z;
    end

    // ---- axis hashes (4 stages each)
    logic [31:0] hx0, hx1, hy0, hy1, hz0, hz1;
    vnf_mix u_hx0 (.clk(clk), .din(mx0_reg), .dout(hx0));
    vnf_mix u_hx1 (.clk(clk), .din(mx1_reg), .dout(hx1));
    vnf_mix u_hy0 (.clk(clk), .din(my0_reg), .dout(hy0));
    vnf_mix u_hy1 (.clk(clk), .din(my1_reg), .dout(hy1));
    vnf_mix u_hz0 (.clk(clk), .din(mz0_reg), .dout(hz0));
    vnf_mix u_hz1 (.clk(clk), .din(mz1_reg), .dout(hz1));

    // seed delayed through sdd_reg to meet hash outputs
    logic [31:0] sdd_reg [5];
    always_ff @(posedge clk)
    begin
        sdd_reg[0] <= sd_reg;
        for (int i = 1; i < 5; i++)
            sdd_reg[i] <= sdd_reg[i-1];
    end

    // ---- corner combine
    logic [31:0] hc_reg [8];
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 8; c++)
            hc_reg[c] <= sdd_reg[4] ^ (c[0] ? hx1 : hx0) ^ (c[1] ? hy1 : hy0)
                ^ (c[2] ? hz1 : hz0);
    end

    // Corner c: bit0 = x, bit1 = y, bit2 = z.
    logic [31:0] hv [8];
    for (genvar g = 0; g < 8; g++)
    begin : g_corner
        vnf_mix u_hc (.clk(clk), .din(hc_reg[g]), .dout(hv[g]));
    end

    // ---- fade, runs alongside hashes (timing aligned below)
    logic [47:0] ft2_reg [3];
    logic [23:0] ft_reg [3];
    logic [23:0] ftd1_reg [3];
    logic [23:0] ftd2_reg [3];
    logic [23:0] t2_reg [3];
    logic [47:0] t3p_reg [3];
    logic [25:0] t2b_reg [3];
    logic [23:0] fs_reg [3];
    logic [26:0] sraw [3];
    always_ff @(posedge clk)
    begin
        ft_reg[0] <= tx_reg; ft_reg[1] <= ty_reg; ft_reg[2] <= tz_reg;
        for (int a = 0; a < 3; a++)
        begin
            ftd1_reg[a] <= ft_reg[a];
            ftd2_reg[a] <= ftd1_reg[a];
            ft2_reg[a] <= ft_reg[a] * ft_reg[a];
            t2_reg[a]  <= ft2_reg[a][47:24];
            t3p_reg[a] <= {24'd0, t2_reg[a]} * {24'd0, ftd2_reg[a]};
            t2b_reg[a] <= {2'd0, t2_reg[a]};
            fs_reg[a]  <= (sraw[a] > 27'(FRAC_MAX)) ? FRAC_MAX : sraw[a][23:0];
        end
    end
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            sraw[a] = 27'(t2b_reg[a]) * 27'd3 - {2'd0, t3p_reg[a][47:24], 1'b0};
    end

    // ft_reg carries t in the cycle after stage A; two more stages meet t2 at the cube.
    // Fade result fs_reg then runs through fdl_reg to meet the corner hashes hv.
    logic [23:0] fdl_reg [5][3];
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            fdl_reg[0][a] <= fs_reg[a];
            for (int i = 1; i < 5; i++)
                fdl_reg[i][a] <= fdl_reg[i-1][a];
        end
    end

    // ---- blend x: multiply stage, then add stage
    logic [47:0] pa_reg [4], pb_reg [4];
    logic [23:0] ax_reg [4];
    logic [23:0] fyx_reg, fzx_reg, fy2_reg, fz2_reg, fz3_reg, fz4_reg;
    logic [24:0] sx_c;
    assign sx_c = FRAC_ONE - {1'b0, fdl_reg[4][0]};
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            pa_reg[k] <= 48'(hv[2*k][23:0]) * 48'(sx_c);
            pb_reg[k] <= 48'(hv[2*k+1][23:0]) * 48'(fdl_reg[4][0]);
        end
        fyx_reg <= fdl_reg[4][1];
        fzx_reg <= fdl_reg[4][2];
        for (int k = 0; k < 4; k++)
            ax_reg[k] <= 24'((pa_reg[k] + pb_reg[k]) >> 24);
        fy2_reg <= fyx_reg;
        fz2_reg <= fzx_reg;
    end

    // ---- blend y: pairs differ in y, k selects z
    logic [47:0] qa_reg [2], qb_reg [2];
    logic [23:0] by_reg [2];
    logic [24:0] sy_c;
    assign sy_c = FRAC_ONE - {1'b0, fy2_reg};
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            qa_reg[k] <= 48'(ax_reg[2*k]) * 48'(sy_c);
            qb_reg[k] <= 48'(ax_reg[2*k+1]) * 48'(fy2_reg);
            by_reg[k] <= 24'((qa_reg[k] + qb_reg[k]) >> 24);
        end
        fz3_reg <= fz2_reg;
        fz4_reg <= fz3_reg;
    end

    // ---- blend z
    logic [47:0] ra_reg, rb_reg;
    logic [23:0] n_reg;
    logic [24:0] sz_c;
    assign sz_c = FRAC_ONE - {1'b0, fz4_reg};
    always_ff @(posedge clk)
    begin
        ra_reg <= 48'(by_reg[0]) * 48'(sz_c);
        rb_reg <= 48'(by_reg[1]) * 48'(fz4_reg);
        n_reg  <= 24'((ra_reg + rb_reg) >> 24);
    end

    // ---- ridge and weighting
    logic [24:0] d_c, rn_c, w_reg;
    logic        op_at_n;
    assign d_c = ({n_reg, 1'b0} >= FRAC_ONE) ? ({n_reg, 1'b0} - FRAC_ONE)
                                             : (FRAC_ONE - {n_reg, 1'b0});
    assign rn_c = op_at_n ? (FRAC_ONE - d_c) : {1'b0, n_reg};
    always_ff @(posedge clk)
        w_reg <= rn_c >> (IDX + 1);

    // ---- coordinate scaling (for the next octave): multiply, then floor/saturate
    logic signed [49:0] sp_reg [3];
    logic [31:0] np_reg [3];
    logic signed [33:0] q_c [3];
    always_ff @(posedge clk)
    begin
        sp_reg[0] <= $signed(in_px) * $signed({1'b0, in_op ? LAC_RIDGE : LAC_PLAIN});
        sp_reg[1] <= $signed(in_py) * $signed({1'b0, in_op ? LAC_RIDGE : LAC_PLAIN});
        sp_reg[2] <= $signed(in_pz) * $signed({1'b0, in_op ? LAC_RIDGE : LAC_PLAIN});
        for (int a = 0; a < 3; a++)
        begin
            if (q_c[a] > 34'sh07fffffff)
                np_reg[a] <= 32'h7fffffff;
            else if (q_c[a] < -34'sh080000000)
                np_reg[a] <= 32'h80000000;
            else
                np_reg[a] <= q_c[a][31:0];
        end
    end
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            q_c[a] = 34'(sp_reg[a] >>> 16);
    end

    // ---- side data delay line; valid, op, seed, total, new point
    localparam int D = LAT;
    logic [D-1:0] v_reg, o_reg;
    logic [31:0] dsd_reg [D];
    logic [24:0] dt_reg [D];
    logic [31:0] dp_reg [D][3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[D-2:0], in_vld};
    end
    always_ff @(posedge clk)
    begin
        o_reg <= {o_reg[D-2:0], in_op};
        dsd_reg[0] <= in_seed;
        dt_reg[0] <= in_total;
        for (int i = 1; i < D; i++)
        begin
            dsd_reg[i] <= dsd_reg[i-1];
            dt_reg[i] <= dt_reg[i-1];
        end
        for (int a = 0; a < 3; a++)
        begin
            dp_reg[2][a] <= np_reg[a];
            for (int i = 3; i < D; i++)
                dp_reg[i][a] <= dp_reg[i-1][a];
            dp_reg[0][a] <= '0;
            dp_reg[1][a] <= '0;
        end
    end
    // o_reg[16] is aligned with n_reg: ridge uses op of the same item.
    assign op_at_n = o_reg[16];

    // total: w_reg is added to dt_reg[17] into sum_reg, then delayed through sd2_reg.
    logic [24:0] sum_reg;
    logic [LAT-20:0] pad_v;
    logic [24:0] sd2_reg [LAT-19];
    assign pad_v = '0;
    always_ff @(posedge clk)
    begin
        sum_reg <= dt_reg[17] + w_reg;
        sd2_reg[0] <= sum_reg;
        for (int i = 1; i < LAT-19; i++)
            sd2_reg[i] <= sd2_reg[i-1];
    end

    assign out_vld   = v_reg[D-1] | (|pad_v);
    assign out_op    = o_reg[D-1];
    assign out_seed  = dsd_reg[D-1];
    assign out_total = sd2_reg[LAT-20];
    assign out_px    = dp_reg[D-1][0];
    assign out_py    = dp_reg[D-1][1];
    assign out_pz    = dp_reg[D-1][2];
endmodule

// ----- dv/value_noise_fbm_3d_tb.sv -----
// Self-checking testbench for the fractal value noise block.
module value_noise_fbm_3d_tb;
    import vnf_pkg::*;

    localparam int OCT = 5;
    localparam int LATENCY = 26 * OCT + 1;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        opcode = OP_PLAIN;
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;
    logic [31:0] pos_z = '0;
    logic [31:0] seed = '0;
    logic        done;
    logic [23:0] noise_value;

    // Expected noise sums, oldest first.
    logic [23:0] noise_due[$];
    int          mismatches = 0;
    longint      cycles = 0;
    int          idle_pct = 0;

    value_noise_fbm_3d #(.OCTAVES(OCT)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .seed(seed),
        .done(done), .noise_value(noise_value)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor: integer hash lattice noise, five octaves.
    // ---------------------------------------------------------------
    function automatic logic [31:0] avalanche(input logic [31:0] v);
        logic [31:0] r;
        r = v ^ (v >> 16);
        r = r * 32'h7feb352d;
        r = r ^ (r >> 15);
        r = r * 32'h846ca68b;
        r = r ^ (r >> 16);
        return r;
    endfunction

    function automatic logic [23:0] lattice_val(input logic [31:0] cx, input logic [31:0] cy,
                                                input logic [31:0] cz, input logic [31:0] s);
        logic [31:0] h;
        h = s;
        h ^= avalanche(cx * 32'd374761393);
        h ^= avalanche(cy * 32'd668265263);
        h ^= avalanche(cz * 32'd2147483647);
        return 24'(avalanche(h) & 32'h00ffffff);
    endfunction

    // 3t^2 - 2t^3 at 24 fractional bits, saturated
    function automatic logic [63:0] smooth24(input logic [63:0] t);
        logic [63:0] t2, t3, s;
        t2 = (t * t) >> 24;
        t3 = (t2 * t) >> 24;
        s  = 3 * t2 - 2 * t3;
        return (s > 64'hffffff) ? 64'hffffff : s;
    endfunction

    function automatic logic [63:0] lerp24(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] s);
        return (a * (64'h1000000 - s) + b * s) >> 24;
    endfunction

    function automatic logic [23:0] cell_noise(input logic [31:0] px, input logic [31:0] py,
                                               input logic [31:0] pz, input logic [31:0] s);
        logic [31:0] x0, y0, z0, x1, y1, z1;
        logic [63:0] fx, fy, fz, a00, a10, a01, a11, b0, b1;
        // arithmetic shift gives the floor cell; +1 goes past the top cell without wrapping
        x0 = $signed(px) >>> 16;
        y0 = $signed(py) >>> 16;
        z0 = $signed(pz) >>> 16;
        x1 = x0 + 1; y1 = y0 + 1; z1 = z0 + 1;
        fx = smooth24({40'd0, px[15:0], 8'd0});
        fy = smooth24({40'd0, py[15:0], 8'd0});
        fz = smooth24({40'd0, pz[15:0], 8'd0});
        a00 = lerp24(lattice_val(x0, y0, z0, s), lattice_val(x1, y0, z0, s), fx);
        a10 = lerp24(lattice_val(x0, y1, z0, s), lattice_val(x1, y1, z0, s), fx);
        a01 = lerp24(lattice_val(x0, y0, z1, s), lattice_val(x1, y0, z1, s), fx);
        a11 = lerp24(lattice_val(x0, y1, z1, s), lattice_val(x1, y1, z1, s), fx);
        b0 = lerp24(a00, a10, fy);
        b1 = lerp24(a01, a11, fy);
        return 24'(lerp24(b0, b1, fz));
    endfunction

    // floor(p*L/2^16) saturated to signed 32 bits
    function automatic logic [31:0] lacunar(input logic [31:0] p, input longint lac);
        longint prod, q;
        prod = longint'($signed(p)) * lac;
        q = prod >>> 16;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic [23:0] fbm_sum(input logic op, input logic [31:0] px,
                                            input logic [31:0] py, input logic [31:0] pz,
                                            input logic [31:0] s0);
        logic [63:0] total, n, d;
        logic [31:0] step;
        longint      lac;
        total = 0;
        step = (op == OP_RIDGE) ? STEP_RIDGE : STEP_PLAIN;
        lac  = (op == OP_RIDGE) ? longint'(LAC_RIDGE) : longint'(LAC_PLAIN);
        for (int i = 0; i < OCT; i++)
        begin
            n = cell_noise(px, py, pz, s0 + i * step);
            if (op == OP_RIDGE)
            begin
                d = 2 * n;
                d = (d >= 64'h1000000) ? d - 64'h1000000 : 64'h1000000 - d;
                n = 64'h1000000 - d;
            end
            total += n >> (i + 1);
            px = lacunar(px, lac);
            py = lacunar(py, lac);
            pz = lacunar(pz, lac);
        end
        // neither sum can overflow 24 bits; the clamp is only a guard
        return (total > 64'hffffff) ? 24'hffffff : total[23:0];
    endfunction

    // ---------------------------------------------------------------
    // Send one request; optionally idle first at the current rate.
    // ---------------------------------------------------------------
    task automatic send_request(input logic op, input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [31:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        opcode <= op;
        pos_x  <= x;
        pos_y  <= y;
        pos_z  <= z;
        seed   <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        noise_due.push_back(fbm_sum(op, x, y, z, s));
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker: done is sampled at the rising edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (noise_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result noise_value=%h", noise_value);
            end
            else
            begin
                logic [23:0] want;
                want = noise_due.pop_front();
                if (noise_value !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_value mismatch: expected %h actual %h",
                                 want, noise_value);
                end
            end
        end
    end

    // Runaway guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0040_0000) - 32'h0020_0000; // near origin
            2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};  // moderate
            default: return $urandom_range(1) ? 32'h7fff_0000 | 16'($urandom)
                                              : 32'h8000_0000 | 16'($urandom);
        endcase
    endfunction

    // Extremes of every field, both operations and wrap cases.
    task automatic test_directed();
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0000ffff, 32'h00010000};
        for (int k = 0; k < 6; k++)
        begin
            send_request(OP_PLAIN, edge_vals[k], edge_vals[(k + 1) % 6], edge_vals[(k + 2) % 6],
                         k[0] ? 32'hffffffff : 32'h0);
            send_request(OP_RIDGE, edge_vals[k], edge_vals[(k + 3) % 6], edge_vals[(k + 5) % 6],
                         k[0] ? 32'h0 : 32'hffffffff);
        end
        // top cell: corner index runs past 0x7fff to 0x8000
        send_request(OP_PLAIN, 32'h7fff8000, 32'h7fff8000, 32'h7fff8000, 32'h12345678);
        send_request(OP_RIDGE, 32'h7fffc000, 32'hffff8000, 32'h7fff4000, 32'h9abcdef0);
        // half cells on every axis: ridged requests with varied seeds
        for (int k = 0; k < 6; k++)
            send_request(OP_RIDGE, 32'h00008000, 32'h00008000, 32'h00008000, k * 32'h1111);
        send_request(OP_PLAIN, 32'hfffe0001, 32'h00020001, 32'hdead0000, 32'hcafef00d);
        end_burst();
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
            send_request($urandom_range(1), rand_coord(), rand_coord(), rand_coord(), $urandom);
        end_burst();
    endtask

    // Drain fully with the sender held off, then resume.
    task automatic test_drain_pause();
        while (noise_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        test_random(20);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 26;
        test_directed();
        test_random(450);
        test_drain_pause();
        idle_pct = 87;
        test_random(430);
        idle_pct = 0;
        test_random(430);

        while (noise_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
